[design/ltc_pkg.sv]
// shared types, constants and keyword tables of the lexical token classifier
`timescale 1ns / 1ps

package ltc_pkg;

   localparam int LINE_LENGTH_MAX = 4096;
   localparam int NUM_KW          = 22;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [11:0] LEN_MAX = 12'hFFF;
   localparam logic [11:0] COL_MAX = (LINE_LENGTH_MAX - 1 < 4095) ?
                                     12'(LINE_LENGTH_MAX - 1) : 12'hFFF;

   localparam logic [2:0] KIND_KEYWORD  = 3'd0;
   localparam logic [2:0] KIND_INTEGER  = 3'd1;
   localparam logic [2:0] KIND_REAL     = 3'd2;
   localparam logic [2:0] KIND_IDENT    = 3'd3;
   localparam logic [2:0] KIND_BAD_ID   = 3'd4;
   localparam logic [2:0] KIND_OPERATOR = 3'd5;

   // keyword text, right-justified, last character in the low byte
   localparam logic [63:0] KW_TEXT [NUM_KW] = '{
      64'("if"), 64'("else"), 64'("while"), 64'("do"), 64'("break"),
      64'("continue"), 64'("int"), 64'("double"), 64'("float"),
      64'("return"), 64'("char"), 64'("case"), 64'("sizeof"), 64'("long"),
      64'("short"), 64'("typedef"), 64'("switch"), 64'("unsigned"),
      64'("void"), 64'("static"), 64'("struct"), 64'("goto")
   };

   localparam logic [3:0] KW_LEN [NUM_KW] = '{
      4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd3, 4'd6, 4'd5, 4'd6, 4'd4,
      4'd4, 4'd6, 4'd4, 4'd5, 4'd7, 4'd6, 4'd8, 4'd4, 4'd6, 4'd6, 4'd4
   };

   typedef struct packed {
      logic [7:0] text_char;
      logic       line_end;
   } ltc_req_type;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [11:0] token_start;
      logic [11:0] token_length;
      logic [4:0]  keyword_index;
      logic [7:0]  operator_char;
      logic        last_of_run;
   } ltc_rsp_type;

   // everything one character produces, queued between front and back
   typedef struct packed {
      logic              tok_valid;
      logic              op_valid;
      logic [11:0]       tok_start;
      logic [11:0]       tok_len;
      logic [NUM_KW-1:0] kw_alive;
      logic              all_digits;
      logic              digits_or_dots;
      logic              seen_dot;
      logic              first_is_digit;
      logic [11:0]       op_start;
      logic [7:0]        op_char;
   } ltc_run_type;

   // character at position pos of keyword idx (pos below the keyword length)
   function automatic logic [7:0] kw_char(input logic [4:0] idx, input logic [2:0] pos);
      logic [3:0] sh;
      sh = KW_LEN[idx] - {1'b0, pos} - 4'd1;
      return KW_TEXT[idx][{sh[2:0], 3'b000} +: 8];
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return c == " " || c == "+" || c == "-" || c == "*" || c == "/" ||
             c == "," || c == ";" || c == ">" || c == "<" || c == "=" ||
             c == "(" || c == ")" || c == "[" || c == "]" || c == "{" ||
             c == "}";
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return c == "+" || c == "-" || c == "*" || c == "/" ||
             c == ">" || c == "<" || c == "=";
   endfunction

endpackage

[design/ltc_front.sv]
// front end: per-character token tracking and incremental keyword matching
`timescale 1ns / 1ps

module ltc_front import ltc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ltc_req_type req_payload,
   input  logic        queue_full,
   output logic        push,
   output ltc_run_type push_run
);

   logic [11:0]       column_ff, column_in;
   logic [11:0]       start_ff, start_in;
   logic [11:0]       len_ff, len_in;
   logic [NUM_KW-1:0] alive_ff, alive_in;
   logic              all_dig_ff, all_dig_in;
   logic              dig_dot_ff, dig_dot_in;
   logic              dot_ff, dot_in;
   logic              first_dig_ff, first_dig_in;

   logic              accept;
   logic [7:0]        c;
   logic              delim, digit, dot;
   logic [11:0]       tok_start_new, len_new;
   logic [NUM_KW-1:0] alive_new;
   logic              all_dig_new, dig_dot_new, dot_new, first_dig_new;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign c         = req_payload.text_char;
   assign delim     = is_delim(c);
   assign digit     = (c >= "0") && (c <= "9");
   assign dot       = (c == ".");

   // token state after taking c as a token character
   always_comb begin
      tok_start_new = (len_ff == 12'd0) ? column_ff : start_ff;
      first_dig_new = (len_ff == 12'd0) ? digit : first_dig_ff;
      for (int i = 0; i < NUM_KW; i++) begin
         alive_new[i] = alive_ff[i] && (len_ff < {8'd0, KW_LEN[i]}) &&
                        (kw_char(5'(i), len_ff[2:0]) == c);
      end
      all_dig_new = all_dig_ff && digit;
      dig_dot_new = dig_dot_ff && (digit || dot);
      dot_new     = dot_ff || dot;
      len_new     = (len_ff < LEN_MAX) ? len_ff + 12'd1 : len_ff;
   end

   always_comb begin
      push_run.op_valid  = delim && is_op(c);
      push_run.op_start  = column_ff;
      push_run.op_char   = c;
      if (delim) begin
         push_run.tok_valid      = (len_ff != 12'd0);
         push_run.tok_start      = start_ff;
         push_run.tok_len        = len_ff;
         push_run.kw_alive       = alive_ff;
         push_run.all_digits     = all_dig_ff;
         push_run.digits_or_dots = dig_dot_ff;
         push_run.seen_dot       = dot_ff;
         push_run.first_is_digit = first_dig_ff;
      end else begin
         push_run.tok_valid      = req_payload.line_end;
         push_run.tok_start      = tok_start_new;
         push_run.tok_len        = len_new;
         push_run.kw_alive       = alive_new;
         push_run.all_digits     = all_dig_new;
         push_run.digits_or_dots = dig_dot_new;
         push_run.seen_dot       = dot_new;
         push_run.first_is_digit = first_dig_new;
      end
      push = accept && (push_run.tok_valid || push_run.op_valid);
   end

   always_comb begin
      column_in    = column_ff;
      start_in     = start_ff;
      len_in       = len_ff;
      alive_in     = alive_ff;
      all_dig_in   = all_dig_ff;
      dig_dot_in   = dig_dot_ff;
      dot_in       = dot_ff;
      first_dig_in = first_dig_ff;
      if (accept) begin
         if (delim || req_payload.line_end) begin
            len_in       = 12'd0;
            alive_in     = '1;
            all_dig_in   = 1'b1;
            dig_dot_in   = 1'b1;
            dot_in       = 1'b0;
            first_dig_in = 1'b0;
         end else begin
            start_in     = tok_start_new;
            len_in       = len_new;
            alive_in     = alive_new;
            all_dig_in   = all_dig_new;
            dig_dot_in   = dig_dot_new;
            dot_in       = dot_new;
            first_dig_in = first_dig_new;
         end
         if (req_payload.line_end) begin
            column_in = 12'd0;
            start_in  = 12'd0;
         end else if (column_ff < COL_MAX) begin
            column_in = column_ff + 12'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= 12'd0;
         start_ff     <= 12'd0;
         len_ff       <= 12'd0;
         alive_ff     <= '1;
         all_dig_ff   <= 1'b1;
         dig_dot_ff   <= 1'b1;
         dot_ff       <= 1'b0;
         first_dig_ff <= 1'b0;
      end else begin
         column_ff    <= column_in;
         start_ff     <= start_in;
         len_ff       <= len_in;
         alive_ff     <= alive_in;
         all_dig_ff   <= all_dig_in;
         dig_dot_ff   <= dig_dot_in;
         dot_ff       <= dot_in;
         first_dig_ff <= first_dig_in;
      end
   end

   // a line end leaves no open token and restarts the column
   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.line_end |=> len_ff == 12'd0 && column_ff == 12'd0)
      else $error("line end did not clear token state");

   // an open token always has a live digit flag consistent with its digits
   a_int_implies_num: assert property (@(posedge clock) disable iff (reset)
      all_dig_ff |-> dig_dot_ff && !dot_ff)
      else $error("number flags inconsistent");

endmodule

[design/ltc_queue.sv]
// short register queue between front end and back end
`timescale 1ns / 1ps

module ltc_queue import ltc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ltc_run_type push_run,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output ltc_run_type head_run
);

   ltc_run_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign full       = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_run   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_W + 1)'(push) - (QUEUE_PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue underflow");

endmodule

[design/ltc_back.sv]
// back end: token class and one result per cycle to output reg unless stalled
`timescale 1ns / 1ps

module ltc_back import ltc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  ltc_run_type head_run,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ltc_rsp_type rsp_payload
);

   logic        rsp_valid_ff, rsp_valid_in;
   ltc_rsp_type rsp_ff, rsp_in;
   logic        op_phase_ff, op_phase_in;

   logic        load;
   logic        send_tok;
   logic        last;
   logic        kw_hit;
   logic [4:0]  kw_idx;
   logic [2:0]  tok_kind;

   // lowest-numbered live keyword of matching length wins
   always_comb begin
      kw_hit = 1'b0;
      kw_idx = 5'd0;
      for (int i = NUM_KW - 1; i >= 0; i--) begin
         if (head_run.kw_alive[i] && head_run.tok_len == {8'd0, KW_LEN[i]}) begin
            kw_hit = 1'b1;
            kw_idx = 5'(i);
         end
      end
      priority if (kw_hit) begin
         tok_kind = KIND_KEYWORD;
      end else if (head_run.all_digits) begin
         tok_kind = KIND_INTEGER;
      end else if (head_run.digits_or_dots && head_run.seen_dot) begin
         tok_kind = KIND_REAL;
      end else if (!head_run.first_is_digit) begin
         tok_kind = KIND_IDENT;
      end else begin
         tok_kind = KIND_BAD_ID;
      end
   end

   assign load     = head_valid && (!rsp_valid_ff || rsp_ready);
   assign send_tok = head_run.tok_valid && !op_phase_ff;
   assign last     = !(send_tok && head_run.op_valid);
   assign pop      = load && last;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      op_phase_in  = op_phase_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         op_phase_in  = !last;
         if (send_tok) begin
            rsp_in.token_kind    = tok_kind;
            rsp_in.token_start   = head_run.tok_start;
            rsp_in.token_length  = head_run.tok_len;
            rsp_in.keyword_index = kw_idx;
            rsp_in.operator_char = 8'd0;
         end else begin
            rsp_in.token_kind    = KIND_OPERATOR;
            rsp_in.token_start   = head_run.op_start;
            rsp_in.token_length  = 12'd1;
            rsp_in.keyword_index = 5'd0;
            rsp_in.operator_char = head_run.op_char;
         end
         rsp_in.last_of_run = last;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         op_phase_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         op_phase_ff  <= op_phase_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // second half of a run only exists for a token followed by an operator
   a_phase_pair: assert property (@(posedge clock) disable iff (reset)
      op_phase_ff |-> head_valid && head_run.tok_valid && head_run.op_valid)
      else $error("operator phase without a pending pair");

endmodule

[design/lexical_token_classifier.sv]
// top level of the lexical token classifier
//
//   channel   direction  payload         handshake
//   req_      in         ltc_req_type    req_valid / req_ready
//   rsp_      out        ltc_rsp_type    rsp_valid / rsp_ready
//
// one character accepted per cycle while the 4-entry run queue has room
// a character gives zero, one or two results; the back end sends one per cycle while
// the output is not stalled, so a token closed by an operator gives two results in turn
// a result is registered in the run queue and then in the output register before it is valid
// synchronous reset clears column, token state, queue and output valid
`timescale 1ns / 1ps

module lexical_token_classifier import ltc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ltc_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ltc_rsp_type rsp_payload
);

   logic        queue_full;
   logic        push;
   ltc_run_type push_run;
   logic        pop;
   logic        head_valid;
   ltc_run_type head_run;

   ltc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_run    (push_run)
   );

   ltc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_run   (push_run),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_run   (head_run)
   );

   ltc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_run    (head_run),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[tb/sv/ltc_token_checker.sv]
// checker of the lexical token classifier: predicts every result and compares it on the fly
`timescale 1ns / 1ps

module ltc_token_checker import ltc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  ltc_req_type req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  ltc_rsp_type rsp_payload,
   output int          mismatch_count,
   output int          pending_count,
   output int          compared_count
);

   localparam logic [11:0] COLUMN_TOP = (LINE_LENGTH_MAX - 1 < 4095) ?
                                        12'(LINE_LENGTH_MAX - 1) : 12'hFFF;
   localparam logic [11:0] LENGTH_TOP = 12'hFFF;

   string kw_spelling [NUM_KW] = '{
      "if", "else", "while", "do", "break", "continue", "int", "double", "float",
      "return", "char", "case", "sizeof", "long", "short", "typedef", "switch",
      "unsigned", "void", "static", "struct", "goto"
   };

   // predicted line and token state
   logic [11:0]       column;
   logic [11:0]       tok_start;
   logic [11:0]       tok_length;
   logic [NUM_KW-1:0] kw_live;
   logic              only_digits;
   logic              only_digits_dots;
   logic              has_dot;
   logic              lead_digit;

   ltc_rsp_type expected_tokens [$];
   int          mismatches = 0;
   int          compared = 0;

   function automatic bit is_separator(input logic [7:0] c);
      case (c)
         " ", "+", "-", "*", "/", ",", ";", ">", "<", "=", "(", ")", "[", "]", "{", "}":
            return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit is_operator_char(input logic [7:0] c);
      case (c)
         "+", "-", "*", "/", ">", "<", "=": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void start_fresh_token();
      tok_length       = '0;
      kw_live          = '1;
      only_digits      = 1'b1;
      only_digits_dots = 1'b1;
      has_dot          = 1'b0;
      lead_digit       = 1'b0;
   endfunction

   function automatic ltc_rsp_type token_result();
      ltc_rsp_type r;
      int          hit;
      r = '0;
      hit = -1;
      r.token_start  = tok_start;
      r.token_length = tok_length;
      // first listed keyword still alive whose length equals the token
      for (int i = 0; i < NUM_KW; i++)
         if (hit < 0 && kw_live[i] && kw_spelling[i].len() == tok_length) hit = i;
      if (hit >= 0) begin
         r.token_kind    = KIND_KEYWORD;
         r.keyword_index = 5'(hit);
      end else if (only_digits) begin
         r.token_kind = KIND_INTEGER;
      end else if (only_digits_dots && has_dot) begin
         r.token_kind = KIND_REAL;
      end else if (!lead_digit) begin
         r.token_kind = KIND_IDENT;
      end else begin
         r.token_kind = KIND_BAD_ID;
      end
      return r;
   endfunction

   function automatic void predict_char(input ltc_req_type item);
      ltc_rsp_type       found [2];
      ltc_rsp_type       op;
      logic [NUM_KW-1:0] next_live;
      logic [7:0]        c;
      bit                digit;
      int                n;
      n = 0;
      c = item.text_char;
      if (is_separator(c)) begin
         if (tok_length != 0) begin
            found[n] = token_result();
            n++;
            start_fresh_token();
         end
         if (is_operator_char(c)) begin
            op = '0;
            op.token_kind    = KIND_OPERATOR;
            op.token_start   = column;
            op.token_length  = 12'd1;
            op.operator_char = c;
            found[n] = op;
            n++;
         end
      end else begin
         digit = (c >= "0" && c <= "9");
         if (tok_length == 0) begin
            tok_start  = column;
            lead_digit = digit;
         end
         next_live = '0;
         for (int i = 0; i < NUM_KW; i++)
            if (kw_live[i] && tok_length < kw_spelling[i].len() &&
                kw_spelling[i][int'(tok_length)] == c)
               next_live[i] = 1'b1;
         kw_live          = next_live;
         only_digits      = only_digits && digit;
         only_digits_dots = only_digits_dots && (digit || c == ".");
         has_dot          = has_dot || c == ".";
         if (tok_length != LENGTH_TOP) tok_length++;
      end
      if (item.line_end) begin
         if (tok_length != 0) begin
            found[n] = token_result();
            n++;
         end
         column    = '0;
         tok_start = '0;
         start_fresh_token();
      end else if (column < COLUMN_TOP) begin
         column++;
      end
      if (n > 0) found[n-1].last_of_run = 1'b1;
      for (int k = 0; k < n; k++) expected_tokens.push_back(found[k]);
   endfunction

   function automatic string describe(input ltc_rsp_type t);
      return $sformatf("kind %0d start %0d length %0d keyword %0d op 8'h%02h last %0b",
                       t.token_kind, t.token_start, t.token_length, t.keyword_index,
                       t.operator_char, t.last_of_run);
   endfunction

   always @(posedge clock) begin
      ltc_rsp_type want;
      bit          bad;
      if (reset) begin
         column    = '0;
         tok_start = '0;
         start_fresh_token();
         expected_tokens.delete();
      end else begin
         if (req_valid && req_ready) predict_char(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t result with none expected: %s", $time, describe(rsp_payload));
            end else begin
               want = expected_tokens.pop_front();
               compared++;
               bad = (rsp_payload.token_kind    !== want.token_kind)    ||
                     (rsp_payload.token_start   !== want.token_start)   ||
                     (rsp_payload.token_length  !== want.token_length)  ||
                     (rsp_payload.keyword_index !== want.keyword_index) ||
                     (rsp_payload.operator_char !== want.operator_char) ||
                     (rsp_payload.last_of_run   !== want.last_of_run);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t result mismatch\n   expected %s\n   actual   %s", $time,
                              describe(want), describe(rsp_payload));
               end
            end
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_tokens.size();
      compared_count <= compared;
   end

endmodule

[tb/sv/tb_lexical_token_classifier.sv]
// testbench top of the lexical token classifier: clock, reset, character stimulus and verdict
`timescale 1ns / 1ps

module tb_lexical_token_classifier;
   import ltc_pkg::*;

   localparam int RANDOM_CHARS    = 1120;
   localparam int LONG_TOKEN      = 300;
   localparam int HOLD_OFF_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ltc_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ltc_rsp_type rsp_payload;

   int mismatch_count;
   int pending_count;
   int compared_count;

   int         chars_sent = 0;
   int         lines_sent = 0;
   bit         char_burst = 1'b0;
   logic [7:0] line_text [$];
   string      delim_set = " +-*/,;><=()[]{}";
   string      keyword_pool [NUM_KW] = '{
      "if", "else", "while", "do", "break", "continue", "int", "double", "float",
      "return", "char", "case", "sizeof", "long", "short", "typedef", "switch",
      "unsigned", "void", "static", "struct", "goto"
   };

   lexical_token_classifier dut (.*);

   ltc_token_checker token_check (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb_lexical_token_classifier failed");
      $finish;
   end

   function automatic logic [7:0] any_letter();
      case ($urandom_range(0, 4))
         0: return "_";
         1: return 8'("A") + 8'($urandom_range(0, 25));
         default: return 8'("a") + 8'($urandom_range(0, 25));
      endcase
   endfunction

   function automatic logic [7:0] any_digit();
      return 8'("0") + 8'($urandom_range(0, 9));
   endfunction

   task automatic add_char(input logic [7:0] c);
      line_text.push_back(c);
   endtask

   task automatic add_word(input string s);
      for (int i = 0; i < s.len(); i++) line_text.push_back(s[i]);
   endtask

   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      gap = char_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= '{text_char: c, line_end: last};
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      chars_sent++;
   endtask

   task automatic send_line();
      char_burst = ($urandom_range(0, 3) == 0);
      foreach (line_text[i]) send_char(line_text[i], i == line_text.size() - 1);
      line_text.delete();
      lines_sent++;
   endtask

   task automatic add_token();
      string w;
      case ($urandom_range(0, 9))
         0, 1: add_word(keyword_pool[$urandom_range(0, NUM_KW - 1)]);
         2: begin
            // near miss: keyword cut short or run on
            w = keyword_pool[$urandom_range(0, NUM_KW - 1)];
            if ($urandom_range(0, 1)) begin
               add_word(w.substr(0, w.len() - 2));
            end else begin
               add_word(w);
               add_char(any_letter());
            end
         end
         3: repeat ($urandom_range(1, 6)) add_char(any_digit());
         4: begin
            repeat ($urandom_range(0, 4)) add_char(any_digit());
            add_char(".");
            repeat ($urandom_range(0, 4))
               add_char(($urandom_range(0, 5) == 0) ? 8'h2E : any_digit());
         end
         5, 6: begin
            add_char(any_letter());
            repeat ($urandom_range(0, 7))
               add_char(($urandom_range(0, 2) == 0) ? any_digit() : any_letter());
         end
         7: begin
            add_char(any_digit());
            repeat ($urandom_range(1, 5)) add_char(any_letter());
         end
         8: begin
            add_char(any_digit());
            add_char(".");
            add_char(any_letter());
         end
         default: repeat ($urandom_range(1, 4)) add_char(8'($urandom_range(0, 255)));
      endcase
   endtask

   // result side: random stalls, bursts, and one long hold-off to back up the queue
   initial begin
      int gap;
      int taken;
      bit rsp_burst;
      taken = 0;
      rsp_burst = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (taken % 32 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
         if (taken == 150) gap = HOLD_OFF_CYCLES;
         else gap = rsp_burst ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
      end
   end

   initial begin
      int drain;
      int stop_at;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // keyword closed by operator, integer closed by line end
      add_word("do+12");
      send_line();
      add_word("1.5/9x");
      send_line();
      // line ending on a plain delimiter: the delimiter closes the token and gives no result of its own
      add_word("_a ");
      send_line();
      // nul, newline and 8'hff are token characters, operator on the line end
      add_char(8'h00);
      add_char(8'h0A);
      add_char(8'hFF);
      add_char("-");
      send_line();
      add_word("goto*<");
      send_line();
      add_word("7");
      send_line();

      // one long line with a long identifier closed by an operator
      for (int i = 0; i < LONG_TOKEN; i++) add_char(any_letter());
      add_char("+");
      add_word("12");
      send_line();

      stop_at = chars_sent + RANDOM_CHARS;
      while (chars_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) add_char(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 6)) begin
               add_token();
               repeat ($urandom_range(1, 2)) add_char(delim_set[$urandom_range(0, 15)]);
            end
            if ($urandom_range(0, 1)) add_token();
         end
         send_line();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      drain = 0;
      while (pending_count != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (40) @(posedge clock);

      if (pending_count != 0) $display("%0d expected results never came out", pending_count);
      $display("%0d characters on %0d lines, one line with a %0d-character identifier",
               chars_sent, lines_sent, LONG_TOKEN);
      $display("%0d results compared, result side held off %0d cycles once",
               compared_count, HOLD_OFF_CYCLES);
      if (mismatch_count == 0 && pending_count == 0)
         $display("tb_lexical_token_classifier passed");
      else
         $display("tb_lexical_token_classifier failed");
      $finish;
   end

endmodule

[sim.f]
design/ltc_pkg.sv
design/ltc_front.sv
design/ltc_queue.sv
design/ltc_back.sv
design/lexical_token_classifier.sv
tb/sv/ltc_token_checker.sv
tb/sv/tb_lexical_token_classifier.sv
